// ----- rtl/vibe_background_pixel_classifier_top_assert.svh -----
// Assertion macros for the background pixel classifier checker.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef VIBE_BACKGROUND_PIXEL_CLASSIFIER_TOP_ASSERT_SVH
`define VIBE_BACKGROUND_PIXEL_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VBPC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define VBPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/vbpc_pkg.sv -----
// Shared constants, types and functions of the background pixel classifier.
// No dependencies.
package vbpc_pkg;
    localparam int NUM_SAMPLES_P = 20;
    localparam int MAX_WIDTH     = 128;
    localparam int MAX_HEIGHT    = 128;
    localparam int COORD_W       = 7;
    localparam int SLOT_W        = 5;
    localparam int PIX_W         = 8;
    localparam int RUN_DEPTH     = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W        = $clog2(RUN_DEPTH);
    localparam int ROW_BITS      = NUM_SAMPLES_P * PIX_W;
    localparam int CNT_W         = $clog2(NUM_SAMPLES_P + 1);
    localparam int CFG_IDX_W     = 3;
    localparam logic [7:0] RUN_MAX   = 8'd255;
    localparam logic [7:0] MASK_FG   = 8'd255;
    localparam logic [7:0] MASK_BG   = 8'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSIST = 3'd4;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TEST = 1'b1;

    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [SLOT_W-1:0]   slot;
        logic [PIX_W-1:0]    data;
    } sample_wr_t;

    function automatic logic signed [1:0] pick_offset(input logic [3:0] pick);
        logic signed [1:0] off;
        case (pick)
            4'd0: off = -2'sd1;
            4'd1: off = 2'sd0;
            4'd2: off = 2'sd1;
            4'd3: off = -2'sd1;
            4'd4: off = 2'sd1;
            4'd5: off = -2'sd1;
            4'd6: off = 2'sd0;
            4'd7: off = 2'sd1;
            default: off = 2'sd0;
        endcase
        return off;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] base,
                                                       input logic signed [1:0] off,
                                                       input logic [7:0] size,
                                                       input logic [8:0] maxv);
        logic signed [9:0] c;
        logic [8:0]        lim;
        lim = {1'b0, size};
        if (lim == 9'd0) lim = 9'd1;
        if (lim > maxv) lim = maxv;
        c = $signed({3'b000, base}) + 10'(off);
        if (c < 0) c = 10'sd0;
        if (c >= $signed({1'b0, lim})) c = $signed({1'b0, lim - 9'd1});
        return c[COORD_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] row,
                                                    input logic [COORD_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
    endfunction
endpackage

// ----- rtl/vbpc_sample_mem.sv -----
// Sample memory: one row of all samples per pixel, byte write, registered read.
// Depends on vbpc_pkg.
module vbpc_sample_mem (
    input  logic                       aclk,
    input  logic                       rd_en,
    input  logic [vbpc_pkg::ADDR_W-1:0] rd_addr,
    output logic [vbpc_pkg::ROW_BITS-1:0] rd_data,
    input  vbpc_pkg::sample_wr_t       wr
);
    import vbpc_pkg::*;

    logic [ROW_BITS-1:0] mem [RUN_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr][wr.slot*PIX_W +: PIX_W] <= wr.data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ----- rtl/vbpc_run_mem.sv -----
// Foreground run count memory, one byte per pixel, registered read.
// Depends on vbpc_pkg.
module vbpc_run_mem (
    input  logic                        aclk,
    input  logic                        rd_en,
    input  logic [vbpc_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                  rd_data,
    input  logic                        wr_en,
    input  logic [vbpc_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                  wr_data
);
    import vbpc_pkg::*;

    logic [7:0] mem [RUN_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ----- rtl/vbpc_match.sv -----
// Match unit: compares a pixel with all stored samples and decides background.
// Depends on vbpc_pkg.
module vbpc_match (
    input  logic [vbpc_pkg::ROW_BITS-1:0] samples,
    input  logic [7:0]                    pixel,
    input  logic [7:0]                    radius,
    input  logic [4:0]                    min_hits,
    output logic                          background
);
    import vbpc_pkg::*;

    logic [NUM_SAMPLES_P-1:0] hit;
    logic [CNT_W-1:0]         count;

    always_comb begin
        logic [7:0] s;
        logic [7:0] d;
        for (int k = 0; k < NUM_SAMPLES_P; k++) begin
            s = samples[k*PIX_W +: PIX_W];
            d = (s > pixel) ? s - pixel : pixel - s;
            hit[k] = d < radius;
        end
    end

    assign count      = CNT_W'($countones(hit));
    assign background = 6'(count) >= 6'(min_hits);
endmodule

// ----- rtl/vibe_background_pixel_classifier_top.sv -----
// Top level of the per-pixel background classifier: control, registers, memories.
// Depends on vbpc_pkg, vbpc_sample_mem, vbpc_run_mem and vbpc_match.
// A load word is written as it is accepted; a test word passes the execute state,
// then the neighbour state if it refreshes a neighbour, as the single write port
// of the sample memory serialises the own and the neighbour refresh. A test word
// also waits in the execute state while the previous result is still held on
// the output. After reset a clearing pass zeroes all 16384 run counts, and no word
// is accepted until it ends. Samples must be loaded before a pixel is tested.
module vibe_background_pixel_classifier_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pix_row, pix_col, pixel, own_take, own_slot, nb_take, nb_row_pick,
    // nb_col_pick, nb_slot, then zero fill
    input  logic [47:0] s_tdata,
    // req_type
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // mask, fg_run
    output logic [15:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [vbpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]  cfg_wdata
);
    import vbpc_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_NB    = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [7:0] radius_reg, width_reg, height_reg, persist_reg;
    logic [4:0] min_reg;
    logic [41:0] item_reg;
    logic        m_valid_reg;
    logic [15:0] m_data_reg;

    logic [COORD_W-1:0] in_row, in_col, it_row, it_col, nb_row, nb_col;
    logic [PIX_W-1:0]   in_pix, it_pix;
    logic [SLOT_W-1:0]  in_slot, it_own_slot, it_nb_slot;
    logic               it_own_take, it_nb_take;
    logic [3:0]         it_rpick, it_cpick;
    logic               accept, out_ok, background;
    logic [ROW_BITS-1:0] samples;
    logic [7:0]         run_rd, run_new;
    logic               own_wr;
    sample_wr_t         swr;
    logic               run_we;
    logic [ADDR_W-1:0]  run_waddr, it_addr;
    logic [7:0]         run_wdata;

    assign in_row  = s_tdata[6:0];
    assign in_col  = s_tdata[13:7];
    assign in_pix  = s_tdata[21:14];
    assign in_slot = s_tdata[27:23];

    assign it_row      = item_reg[6:0];
    assign it_col      = item_reg[13:7];
    assign it_pix      = item_reg[21:14];
    assign it_own_take = item_reg[22];
    assign it_own_slot = item_reg[27:23];
    assign it_nb_take  = item_reg[28];
    assign it_rpick    = item_reg[32:29];
    assign it_cpick    = item_reg[36:33];
    assign it_nb_slot  = item_reg[41:37];
    assign it_addr     = cell_addr(it_row, it_col);

    assign nb_row = clamp_coord(it_row, pick_offset(it_rpick), height_reg, 9'(MAX_HEIGHT));
    assign nb_col = clamp_coord(it_col, pick_offset(it_cpick), width_reg, 9'(MAX_WIDTH));

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_ok   = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    vbpc_match u_match (
        .samples     (samples),
        .pixel       (it_pix),
        .radius      (radius_reg),
        .min_hits    (min_reg),
        .background  (background)
    );

    always_comb begin
        if (background) begin
            run_new = 8'd0;
        end else if (run_rd < RUN_MAX) begin
            run_new = run_rd + 8'd1;
        end else begin
            run_new = RUN_MAX;
        end
        own_wr = it_own_take && (background || (run_new > persist_reg));
    end

    always_comb begin
        swr.en   = 1'b0;
        swr.addr = cell_addr(in_row, in_col);
        swr.slot = in_slot;
        swr.data = in_pix;
        case (state_reg)
            ST_IDLE: begin
                swr.en = accept && (s_tuser == REQ_LOAD)
                         && (6'(in_slot) < 6'(NUM_SAMPLES_P));
            end
            ST_EXEC: begin
                swr.en   = out_ok && own_wr && (6'(it_own_slot) < 6'(NUM_SAMPLES_P));
                swr.addr = it_addr;
                swr.slot = it_own_slot;
                swr.data = it_pix;
            end
            ST_NB: begin
                swr.en   = 1'b1;
                swr.addr = cell_addr(nb_row, nb_col);
                swr.slot = it_nb_slot;
                swr.data = it_pix;
            end
            default: begin
                swr.en = 1'b0;
            end
        endcase
    end

    always_comb begin
        run_we    = 1'b0;
        run_waddr = it_addr;
        run_wdata = run_new;
        case (state_reg)
            ST_CLEAR: begin
                run_we    = 1'b1;
                run_waddr = clr_cnt_reg;
                run_wdata = 8'd0;
            end
            ST_EXEC: begin
                run_we = out_ok;
            end
            default: begin
                run_we = 1'b0;
            end
        endcase
    end

    vbpc_sample_mem u_samples (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (cell_addr(in_row, in_col)),
        .rd_data (samples),
        .wr      (swr)
    );

    vbpc_run_mem u_runs (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (cell_addr(in_row, in_col)),
        .rd_data (run_rd),
        .wr_en   (run_we),
        .wr_addr (run_waddr),
        .wr_data (run_wdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == ADDR_W'(RUN_DEPTH - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept && (s_tuser == REQ_TEST)) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_ok) begin
                    if (background && it_nb_take && (6'(it_nb_slot) < 6'(NUM_SAMPLES_P))) begin
                        state_next = ST_NB;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_NB: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            radius_reg  <= 8'd20;
            min_reg     <= 5'd2;
            width_reg   <= 8'd128;
            height_reg  <= 8'd128;
            persist_reg <= 8'd50;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (state_reg == ST_EXEC && out_ok) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_RADIUS:  radius_reg  <= cfg_wdata;
                    CFG_MIN:     min_reg     <= cfg_wdata[4:0];
                    CFG_WIDTH:   width_reg   <= cfg_wdata;
                    CFG_HEIGHT:  height_reg  <= cfg_wdata;
                    CFG_PERSIST: persist_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) item_reg <= s_tdata[41:0];
        if (state_reg == ST_EXEC && out_ok) begin
            m_data_reg <= {run_new, background ? MASK_BG : MASK_FG};
        end
    end
endmodule

// ----- rtl/vbpc_checker.sv -----
// Port-level checker of the background pixel classifier, bound to the top level.
// Depends on vibe_background_pixel_classifier_top_assert.svh.
`include "vibe_background_pixel_classifier_top_assert.svh"

module vbpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    `VBPC_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))
    `VBPC_ASSERT_NOW(a_mask_code, m_tvalid, m_tdata[7:0] == 8'd0 || m_tdata[7:0] == 8'd255)
    `VBPC_ASSERT_NOW(a_bg_run_zero, m_tvalid && m_tdata[7:0] == 8'd0, m_tdata[15:8] == 8'd0)
    `VBPC_ASSERT_NEXT(a_test_busy, s_tvalid && s_tready && s_tuser, !s_tready)
endmodule

bind vibe_background_pixel_classifier_top vbpc_checker u_vbpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
